@@ sv/gated_reverb_envelope_generator_macros.svh @@
// Assertion helpers, clocked on clock and disabled in reset.
`ifndef GATED_REVERB_ENVELOPE_GENERATOR_MACROS_SVH
`define GATED_REVERB_ENVELOPE_GENERATOR_MACROS_SVH

// Same-cycle implication.
`define GRE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define GRE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/gre_pkg.sv @@
package gre_pkg;

   localparam int LEVEL_W  = 23;
   localparam int GAIN_W   = 25;
   localparam int PHASE_W  = 21;
   localparam int OUT_W    = 17;
   localparam int SAMPLE_W = 24;
   localparam int PROD_W   = 49;
   localparam int ADDR_W   = 5;
   localparam int DATA_W   = 32;
   localparam int SMOOTH_SHIFT = 7;

   localparam logic [GAIN_W-1:0]  UNITY_Q24 = 25'h100_0000;
   localparam logic [PHASE_W-1:0] PHASE_MAX = 21'h1F_FFFF;
   localparam logic [16:0]        SUSTAIN_MAX = 17'd65536;

   localparam logic [2:0] REG_TRIGGER_RISE  = 3'd0;
   localparam logic [2:0] REG_TRIGGER_FALL  = 3'd1;
   localparam logic [2:0] REG_ATTACK_WEIGHT = 3'd2;
   localparam logic [2:0] REG_RELEASE_WGT   = 3'd3;
   localparam logic [2:0] REG_HOLD_LENGTH   = 3'd4;
   localparam logic [2:0] REG_DECAY_FACTOR  = 3'd5;
   localparam logic [2:0] REG_RELEASE_FACT  = 3'd6;
   localparam logic [2:0] REG_SUSTAIN_LEVEL = 3'd7;

   typedef struct packed {
      logic [22:0] trigger_rise_level;
      logic [22:0] trigger_fall_level;
      logic [15:0] attack_weight;
      logic [15:0] release_weight;
      logic [19:0] hold_length;
      logic [23:0] decay_factor;
      logic [23:0] release_factor;
      logic [16:0] sustain_level;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic follow;
      logic gate;
      logic mulr;
      logic muln;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } sts_type;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_FOLLOW = 6'b000010,
      ST_GATE   = 6'b000100,
      ST_MULR   = 6'b001000,
      ST_MULN   = 6'b010000,
      ST_FIN    = 6'b100000
   } state_type;

endpackage

@@ sv/gre_csr.sv @@
module gre_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [gre_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [gre_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [gre_pkg::DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready,
   output gre_pkg::cfg_type            cfg
);

   gre_pkg::cfg_type cfg_ff;
   gre_pkg::cfg_type cfg_in;
   logic [2:0]       index;
   logic [16:0]      sustain_raw;
   logic             wr_en;

   assign csr_pready  = 1'b1;
   assign index       = csr_paddr[4:2];
   assign sustain_raw = csr_pwdata[16:0];
   assign wr_en       = csr_psel & csr_penable & csr_pwrite;
   assign cfg         = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            gre_pkg::REG_TRIGGER_RISE:  cfg_in.trigger_rise_level = csr_pwdata[22:0];
            gre_pkg::REG_TRIGGER_FALL:  cfg_in.trigger_fall_level = csr_pwdata[22:0];
            gre_pkg::REG_ATTACK_WEIGHT: cfg_in.attack_weight      = csr_pwdata[15:0];
            gre_pkg::REG_RELEASE_WGT:   cfg_in.release_weight     = csr_pwdata[15:0];
            gre_pkg::REG_HOLD_LENGTH:   cfg_in.hold_length        = csr_pwdata[19:0];
            gre_pkg::REG_DECAY_FACTOR:  cfg_in.decay_factor       = csr_pwdata[23:0];
            gre_pkg::REG_RELEASE_FACT:  cfg_in.release_factor     = csr_pwdata[23:0];
            gre_pkg::REG_SUSTAIN_LEVEL: cfg_in.sustain_level      =
               (sustain_raw > gre_pkg::SUSTAIN_MAX) ? gre_pkg::SUSTAIN_MAX : sustain_raw;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         gre_pkg::REG_TRIGGER_RISE:  csr_prdata = {9'd0, cfg_ff.trigger_rise_level};
         gre_pkg::REG_TRIGGER_FALL:  csr_prdata = {9'd0, cfg_ff.trigger_fall_level};
         gre_pkg::REG_ATTACK_WEIGHT: csr_prdata = {16'd0, cfg_ff.attack_weight};
         gre_pkg::REG_RELEASE_WGT:   csr_prdata = {16'd0, cfg_ff.release_weight};
         gre_pkg::REG_HOLD_LENGTH:   csr_prdata = {12'd0, cfg_ff.hold_length};
         gre_pkg::REG_DECAY_FACTOR:  csr_prdata = {8'd0, cfg_ff.decay_factor};
         gre_pkg::REG_RELEASE_FACT:  csr_prdata = {8'd0, cfg_ff.release_factor};
         gre_pkg::REG_SUSTAIN_LEVEL: csr_prdata = {15'd0, cfg_ff.sustain_level};
         default:                    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_rise_level <= 23'd132767;
         cfg_ff.trigger_fall_level <= 23'd74660;
         cfg_ff.attack_weight      <= 16'd21000;
         cfg_ff.release_weight     <= 16'd171;
         cfg_ff.hold_length        <= 20'd9600;
         cfg_ff.decay_factor       <= 24'd16773000;
         cfg_ff.release_factor     <= 24'd16770000;
         cfg_ff.sustain_level      <= 17'd16384;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ sv/gre_ctrl.sv @@
`include "gated_reverb_envelope_generator_macros.svh"

module gre_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  gre_pkg::sts_type sts,
   output gre_pkg::cmd_type cmd
);

   gre_pkg::state_type state_ff;
   gre_pkg::state_type state_in;

   assign req_ready  = (state_ff == gre_pkg::ST_IDLE);
   assign cmd.load   = req_ready & req_valid;
   assign cmd.follow = (state_ff == gre_pkg::ST_FOLLOW);
   assign cmd.gate   = (state_ff == gre_pkg::ST_GATE);
   assign cmd.mulr   = (state_ff == gre_pkg::ST_MULR);
   assign cmd.muln   = (state_ff == gre_pkg::ST_MULN);
   assign cmd.emit   = (state_ff == gre_pkg::ST_FIN) & sts.out_free;

   always_comb begin
      unique case (state_ff)
         gre_pkg::ST_IDLE:   state_in = req_valid ? gre_pkg::ST_FOLLOW : gre_pkg::ST_IDLE;
         gre_pkg::ST_FOLLOW: state_in = gre_pkg::ST_GATE;
         gre_pkg::ST_GATE:   state_in = gre_pkg::ST_MULR;
         gre_pkg::ST_MULR:   state_in = gre_pkg::ST_MULN;
         gre_pkg::ST_MULN:   state_in = gre_pkg::ST_FIN;
         gre_pkg::ST_FIN:    state_in = sts.out_free ? gre_pkg::ST_IDLE : gre_pkg::ST_FIN;
         default:            state_in = gre_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gre_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `GRE_ASSERT_NEXT(a_accept_starts, req_valid && req_ready, state_ff == gre_pkg::ST_FOLLOW, "accepted beat did not start work")
   `GRE_ASSERT_NEXT(a_fin_waits, state_ff == gre_pkg::ST_FIN && !sts.out_free, state_ff == gre_pkg::ST_FIN, "result dropped while output busy")
   `GRE_ASSERT_NEXT(a_emit_idle, cmd.emit, req_ready, "not ready after result handed over")

endmodule

@@ sv/gre_dp.sv @@
`include "gated_reverb_envelope_generator_macros.svh"

module gre_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  gre_pkg::cfg_type                    cfg,
   input  gre_pkg::cmd_type                    cmd,
   output gre_pkg::sts_type                    sts,
   input  logic signed [gre_pkg::SAMPLE_W-1:0] req_sample_left,
   input  logic signed [gre_pkg::SAMPLE_W-1:0] req_sample_right,
   input  logic                                req_block_end,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [gre_pkg::OUT_W-1:0]           rsp_envelope_gain,
   output logic                                rsp_gate_open,
   output logic                                rsp_releasing,
   output logic                                rsp_block_end_out
);

   function automatic logic [gre_pkg::LEVEL_W-1:0] magnitude(input logic [23:0] v);
      logic [23:0] m;
      m = v[23] ? (~v + 24'd1) : v;
      return m[23] ? 23'h7F_FFFF : m[22:0];
   endfunction

   // item beat registers
   logic [gre_pkg::LEVEL_W-1:0] diff_ff;
   logic                        up_ff;
   logic                        block_end_ff;
   logic [gre_pkg::PROD_W-1:0]  prod_ff;
   logic [gre_pkg::GAIN_W-1:0]  target_ff;
   logic                        decay_en_ff;

   // algorithm state
   logic [gre_pkg::LEVEL_W-1:0] follower_ff;
   logic                        gate_ff;
   logic                        rel_active_ff;
   logic [gre_pkg::PHASE_W-1:0] phase_ff;
   logic [gre_pkg::GAIN_W-1:0]  nat_ff;
   logic [gre_pkg::GAIN_W-1:0]  rel_gain_ff;
   logic [gre_pkg::GAIN_W-1:0]  smooth_ff;

   // output register
   logic                        rsp_valid_ff;
   logic [gre_pkg::OUT_W-1:0]   rsp_gain_ff;
   logic                        rsp_gate_ff;
   logic                        rsp_rel_ff;
   logic                        rsp_end_ff;

   logic [gre_pkg::LEVEL_W-1:0] mag_l, mag_r, mag;
   logic [gre_pkg::LEVEL_W-1:0] diff_in;
   logic [gre_pkg::GAIN_W-1:0]  mul_a;
   logic [23:0]                 mul_b;
   logic [gre_pkg::LEVEL_W-1:0] step;
   logic [gre_pkg::LEVEL_W-1:0] follower_new;
   logic [gre_pkg::LEVEL_W-1:0] threshold;
   logic                        now_above;
   logic                        rise_edge, fall_edge;
   logic                        past_hold;
   logic [gre_pkg::GAIN_W-1:0]  nat_now;
   logic [gre_pkg::GAIN_W-1:0]  sustain_q24;
   logic [gre_pkg::GAIN_W-1:0]  target_in;
   logic [gre_pkg::GAIN_W-1:0]  smooth_delta;
   logic [gre_pkg::GAIN_W-1:0]  smooth_in;

   assign mag_l   = magnitude(req_sample_left);
   assign mag_r   = magnitude(req_sample_right);
   assign mag     = (mag_l > mag_r) ? mag_l : mag_r;
   assign diff_in = (mag > follower_ff) ? (mag - follower_ff) : (follower_ff - mag);

   always_comb begin
      if (cmd.follow) begin
         mul_a = {2'd0, diff_ff};
         mul_b = {8'd0, up_ff ? cfg.attack_weight : cfg.release_weight};
      end else if (cmd.mulr) begin
         mul_a = rel_gain_ff;
         mul_b = cfg.release_factor;
      end else begin
         mul_a = nat_ff;
         mul_b = cfg.decay_factor;
      end
   end

   assign step         = prod_ff[38:16];
   assign follower_new = up_ff ? (follower_ff + step) : (follower_ff - step);
   assign threshold    = gate_ff ? cfg.trigger_fall_level : cfg.trigger_rise_level;
   assign now_above    = follower_new > threshold;
   assign rise_edge    = now_above & ~gate_ff;
   assign fall_edge    = ~now_above & gate_ff;
   assign past_hold    = phase_ff >= {1'b0, cfg.hold_length};
   assign nat_now      = past_hold ? nat_ff : gre_pkg::UNITY_Q24;
   assign sustain_q24  = {cfg.sustain_level, 8'd0};

   always_comb begin
      if (rel_active_ff) begin
         target_in = rel_gain_ff;
      end else if (!past_hold) begin
         target_in = gre_pkg::UNITY_Q24;
      end else if (gate_ff && (nat_ff < sustain_q24)) begin
         target_in = sustain_q24;
      end else begin
         target_in = nat_ff;
      end
   end

   always_comb begin
      if (target_ff >= smooth_ff) begin
         smooth_delta = (target_ff - smooth_ff) >> gre_pkg::SMOOTH_SHIFT;
         smooth_in    = smooth_ff + smooth_delta;
      end else begin
         smooth_delta = (smooth_ff - target_ff) >> gre_pkg::SMOOTH_SHIFT;
         smooth_in    = smooth_ff - smooth_delta;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         diff_ff      <= diff_in;
         up_ff        <= mag > follower_ff;
         block_end_ff <= req_block_end;
      end
      if (cmd.follow | cmd.mulr | cmd.muln) begin
         prod_ff <= mul_a * mul_b;
      end
      if (cmd.mulr) begin
         target_ff   <= target_in;
         decay_en_ff <= past_hold;
      end
      if (cmd.emit) begin
         rsp_gain_ff <= smooth_ff[24:8];
         rsp_gate_ff <= gate_ff;
         rsp_rel_ff  <= rel_active_ff;
         rsp_end_ff  <= block_end_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         follower_ff   <= '0;
         gate_ff       <= 1'b0;
         rel_active_ff <= 1'b0;
         phase_ff      <= '0;
         nat_ff        <= gre_pkg::UNITY_Q24;
         rel_gain_ff   <= '0;
         smooth_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.gate) begin
            follower_ff <= follower_new;
            gate_ff     <= now_above;
            if (rise_edge) begin
               phase_ff      <= '0;
               nat_ff        <= gre_pkg::UNITY_Q24;
               rel_active_ff <= 1'b0;
            end else if (fall_edge && (nat_now < sustain_q24)) begin
               rel_active_ff <= 1'b1;
               rel_gain_ff   <= smooth_ff;
            end
         end
         if (cmd.mulr && (phase_ff != gre_pkg::PHASE_MAX)) begin
            phase_ff <= phase_ff + 21'd1;
         end
         if (cmd.muln) begin
            if (rel_active_ff) begin
               rel_gain_ff <= prod_ff[48:24];
            end
            smooth_ff <= smooth_in;
         end
         if (cmd.emit && decay_en_ff) begin
            nat_ff <= prod_ff[48:24];
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.out_free      = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_envelope_gain = rsp_gain_ff;
   assign rsp_gate_open     = rsp_gate_ff;
   assign rsp_releasing     = rsp_rel_ff;
   assign rsp_block_end_out = rsp_end_ff;

   `GRE_ASSERT_NOW(a_smooth_bound, 1'b1, smooth_ff <= gre_pkg::UNITY_Q24, "smoothed gain above unity")
   `GRE_ASSERT_NOW(a_release_bound, 1'b1, rel_gain_ff <= gre_pkg::UNITY_Q24, "release gain above unity")
   `GRE_ASSERT_NEXT(a_emit_valid, cmd.emit, rsp_valid_ff, "emitted result not presented")

endmodule

@@ sv/gated_reverb_envelope_generator.sv @@
// Channel   Direction  Handshake                  Payload
// req       in         req_valid / req_ready      sample_left, sample_right, block_end
// rsp       out        rsp_valid / rsp_ready      envelope_gain, gate_open, releasing,
//                                                 block_end_out
// csr       in         psel/penable/pwrite/pready 8 registers at 4*index, 32-bit data
//
// Each beat passes the follow, gate, release, decay and finish states in turn; one
// shared 25x24 multiplier is used three times in series (follower, release, decay).
// The result is loaded into the output register in the finish state.
// A result waiting on rsp_ready holds the last step; the next beat is taken once
// the result register has been loaded.
// Reset is synchronous and returns registers and envelope state to defaults.
module gated_reverb_envelope_generator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [gre_pkg::SAMPLE_W-1:0] req_sample_left,
   input  logic signed [gre_pkg::SAMPLE_W-1:0] req_sample_right,
   input  logic                                req_block_end,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [gre_pkg::OUT_W-1:0]           rsp_envelope_gain,
   output logic                                rsp_gate_open,
   output logic                                rsp_releasing,
   output logic                                rsp_block_end_out,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [gre_pkg::ADDR_W-1:0]          csr_paddr,
   input  logic [gre_pkg::DATA_W-1:0]          csr_pwdata,
   output logic [gre_pkg::DATA_W-1:0]          csr_prdata,
   output logic                                csr_pready
);

   gre_pkg::cfg_type cfg;
   gre_pkg::cmd_type cmd;
   gre_pkg::sts_type sts;

   gre_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   gre_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   gre_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .cmd               (cmd),
      .sts               (sts),
      .req_sample_left   (req_sample_left),
      .req_sample_right  (req_sample_right),
      .req_block_end     (req_block_end),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_envelope_gain (rsp_envelope_gain),
      .rsp_gate_open     (rsp_gate_open),
      .rsp_releasing     (rsp_releasing),
      .rsp_block_end_out (rsp_block_end_out)
   );

endmodule

@@ verif/tb_gated_reverb_envelope_generator.sv @@
module tb_gated_reverb_envelope_generator;

   localparam int STALL_LIMIT = 2000;

   typedef struct packed {
      logic [gre_pkg::SAMPLE_W-1:0] left;
      logic [gre_pkg::SAMPLE_W-1:0] right;
      logic                         blk;
   } sample_beat_type;

   typedef struct packed {
      logic [gre_pkg::OUT_W-1:0] gain;
      logic                      gate;
      logic                      rel;
      logic                      blk;
   } env_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic signed [gre_pkg::SAMPLE_W-1:0] req_sample_left = '0;
   logic signed [gre_pkg::SAMPLE_W-1:0] req_sample_right = '0;
   logic                                req_block_end = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic [gre_pkg::OUT_W-1:0]           rsp_envelope_gain;
   logic                                rsp_gate_open;
   logic                                rsp_releasing;
   logic                                rsp_block_end_out;
   logic                                csr_psel = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite = 1'b0;
   logic [gre_pkg::ADDR_W-1:0]          csr_paddr = '0;
   logic [gre_pkg::DATA_W-1:0]          csr_pwdata = '0;
   logic [gre_pkg::DATA_W-1:0]          csr_prdata;
   logic                                csr_pready;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   gated_reverb_envelope_generator dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample_left   (req_sample_left),
      .req_sample_right  (req_sample_right),
      .req_block_end     (req_block_end),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_envelope_gain (rsp_envelope_gain),
      .rsp_gate_open     (rsp_gate_open),
      .rsp_releasing     (rsp_releasing),
      .rsp_block_end_out (rsp_block_end_out),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   // register shadow, reset values
   gre_pkg::cfg_type level_cfg = '{
      trigger_rise_level: 23'd132767,
      trigger_fall_level: 23'd74660,
      attack_weight:      16'd21000,
      release_weight:     16'd171,
      hold_length:        20'd9600,
      decay_factor:       24'd16773000,
      release_factor:     24'd16770000,
      sustain_level:      17'd16384
   };

   // envelope state
   logic [gre_pkg::LEVEL_W-1:0] follow_lvl = '0;
   logic                        gate_st = 1'b0;
   logic                        rel_st = 1'b0;
   logic [gre_pkg::PHASE_W-1:0] phase_cnt = '0;
   logic [gre_pkg::GAIN_W-1:0]  nat_gain = gre_pkg::UNITY_Q24;
   logic [gre_pkg::GAIN_W-1:0]  rel_gain = '0;
   logic [gre_pkg::GAIN_W-1:0]  smooth_gain = '0;

   sample_beat_type sample_backlog[$];
   env_beat_type    expected_env[$];
   int              beats_queued = 0;
   int              beats_in = 0;
   int              err_count = 0;
   int              stall_cycles = 0;
   logic            steady;

   assign steady = (beats_in >= 300) && (beats_in < 550);

   function automatic logic [gre_pkg::LEVEL_W-1:0] sample_magnitude(
         logic [gre_pkg::SAMPLE_W-1:0] s);
      logic [gre_pkg::SAMPLE_W:0] m;
      m = s[gre_pkg::SAMPLE_W-1] ? (25'h100_0000 - {1'b0, s}) : {1'b0, s};
      return (m > 25'h7F_FFFF) ? 23'h7F_FFFF : m[gre_pkg::LEVEL_W-1:0];
   endfunction

   function automatic logic [gre_pkg::GAIN_W-1:0] scale_q24(logic [gre_pkg::GAIN_W-1:0] g,
                                                            logic [23:0] f);
      logic [63:0] wide;
      wide = 64'(g) * 64'(f);
      return wide[48:24];
   endfunction

   function automatic env_beat_type envelope_step(sample_beat_type s);
      logic [gre_pkg::LEVEL_W-1:0] ml, mr, mag;
      logic [63:0]                 wide;
      logic [gre_pkg::GAIN_W-1:0]  sustain_q24, target, nat_now;
      logic [gre_pkg::PHASE_W-1:0] hold;
      logic                        now_above;
      env_beat_type                r;
      ml = sample_magnitude(s.left);
      mr = sample_magnitude(s.right);
      mag = (ml > mr) ? ml : mr;
      sustain_q24 = {level_cfg.sustain_level, 8'h00};
      hold = gre_pkg::PHASE_W'(level_cfg.hold_length);

      if (mag > follow_lvl) begin
         wide = (64'(level_cfg.attack_weight) * 64'(mag - follow_lvl)) >> 16;
         follow_lvl = follow_lvl + wide[gre_pkg::LEVEL_W-1:0];
      end else begin
         wide = (64'(level_cfg.release_weight) * 64'(follow_lvl - mag)) >> 16;
         follow_lvl = follow_lvl - wide[gre_pkg::LEVEL_W-1:0];
      end

      now_above = follow_lvl > (gate_st ? level_cfg.trigger_fall_level
                                        : level_cfg.trigger_rise_level);
      if (now_above && !gate_st) begin
         phase_cnt = '0;
         nat_gain = gre_pkg::UNITY_Q24;
         rel_st = 1'b0;
      end else if (!now_above && gate_st) begin
         nat_now = (phase_cnt >= hold) ? nat_gain : gre_pkg::UNITY_Q24;
         if (nat_now < sustain_q24) begin
            rel_st = 1'b1;
            rel_gain = smooth_gain;
         end
      end
      gate_st = now_above;

      if (rel_st) begin
         target = rel_gain;
         rel_gain = scale_q24(rel_gain, level_cfg.release_factor);
      end else if (phase_cnt < hold) begin
         target = gre_pkg::UNITY_Q24;
      end else begin
         target = nat_gain;
         if (gate_st && target < sustain_q24) target = sustain_q24;
      end

      if (phase_cnt >= hold)
         nat_gain = scale_q24(nat_gain, level_cfg.decay_factor);
      if (phase_cnt != gre_pkg::PHASE_MAX) phase_cnt = phase_cnt + 1'b1;

      if (target >= smooth_gain)
         smooth_gain = smooth_gain + ((target - smooth_gain) >> gre_pkg::SMOOTH_SHIFT);
      else
         smooth_gain = smooth_gain - ((smooth_gain - target) >> gre_pkg::SMOOTH_SHIFT);

      r.gain = smooth_gain[gre_pkg::GAIN_W-1:8];
      r.gate = gate_st;
      r.rel = rel_st;
      r.blk = s.blk;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got 0x%0h, want 0x%0h (beat %0d)", what, got, want, beats_in);
      err_count++;
   endtask

   // sample driver
   always @(posedge clock) begin
      sample_beat_type nxt;
      logic            slot_free;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_env.push_back(envelope_step('{req_sample_left, req_sample_right,
                                                   req_block_end}));
            beats_in++;
         end
         slot_free = !req_valid || req_ready;
         if (slot_free) begin
            if (sample_backlog.size() != 0 && (steady || $urandom_range(99) >= 22)) begin
               nxt = sample_backlog.pop_front();
               req_valid <= 1'b1;
               req_sample_left <= nxt.left;
               req_sample_right <= nxt.right;
               req_block_end <= nxt.blk;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      env_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_env.size() == 0) begin
            report_mismatch("unexpected beat", rsp_envelope_gain, '0);
         end else begin
            want = expected_env.pop_front();
            if (rsp_envelope_gain !== want.gain)
               report_mismatch("envelope_gain", rsp_envelope_gain, want.gain);
            if (rsp_gate_open !== want.gate)
               report_mismatch("gate_open", rsp_gate_open, want.gate);
            if (rsp_releasing !== want.rel)
               report_mismatch("releasing", rsp_releasing, want.rel);
            if (rsp_block_end_out !== want.blk)
               report_mismatch("block_end_out", rsp_block_end_out, want.blk);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= steady || ($urandom_range(99) >= 22);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles == STALL_LIMIT) begin
            $display("gated_reverb_envelope_generator test failed");
            $finish;
         end
      end
   end

   task automatic push_beat(logic [gre_pkg::SAMPLE_W-1:0] left,
                            logic [gre_pkg::SAMPLE_W-1:0] right, logic blk);
      sample_backlog.push_back('{left, right, blk});
      beats_queued++;
   endtask

   function automatic logic [gre_pkg::SAMPLE_W-1:0] signed_sample(int unsigned mag);
      logic [gre_pkg::SAMPLE_W-1:0] m;
      m = mag[gre_pkg::SAMPLE_W-1:0];
      return $urandom_range(1) ? -m : m;
   endfunction

   // mostly hits (loud burst then quiet tail) sized against the current levels
   task automatic run_random(int n);
      int                           goal;
      int unsigned                  lo, qhi, a, b, loud_n, quiet_n;
      logic [gre_pkg::SAMPLE_W-1:0] la, lb;
      goal = beats_queued + n;
      while (beats_queued < goal) begin
         if ($urandom_range(99) < 80) begin
            lo = (level_cfg.trigger_rise_level == 23'h7F_FFFF) ? 32'h7F_FFFF
                 : level_cfg.trigger_rise_level + 1;
            qhi = level_cfg.trigger_fall_level / 2;
            loud_n = $urandom_range(12, 1);
            quiet_n = $urandom_range(30, 1);
            repeat (loud_n) begin
               a = $urandom_range(32'h7F_FFFF, lo);
               b = $urandom_range(a, 0);
               la = ($urandom_range(15) == 0) ? 24'h80_0000 : signed_sample(a);
               lb = signed_sample(b);
               if ($urandom_range(1)) push_beat(la, lb, $urandom_range(7) == 0);
               else push_beat(lb, la, $urandom_range(7) == 0);
            end
            repeat (quiet_n)
               push_beat(signed_sample($urandom_range(qhi, 0)),
                         signed_sample($urandom_range(qhi, 0)), $urandom_range(7) == 0);
         end else begin
            push_beat($urandom(), $urandom(), $urandom_range(1));
         end
      end
   endtask

   task automatic settle();
      while (!(beats_in == beats_queued && expected_env.size() == 0)) @(negedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [gre_pkg::DATA_W-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         gre_pkg::REG_TRIGGER_RISE:  level_cfg.trigger_rise_level = value[22:0];
         gre_pkg::REG_TRIGGER_FALL:  level_cfg.trigger_fall_level = value[22:0];
         gre_pkg::REG_ATTACK_WEIGHT: level_cfg.attack_weight = value[15:0];
         gre_pkg::REG_RELEASE_WGT:   level_cfg.release_weight = value[15:0];
         gre_pkg::REG_HOLD_LENGTH:   level_cfg.hold_length = value[19:0];
         gre_pkg::REG_DECAY_FACTOR:  level_cfg.decay_factor = value[23:0];
         gre_pkg::REG_RELEASE_FACT:  level_cfg.release_factor = value[23:0];
         gre_pkg::REG_SUSTAIN_LEVEL: level_cfg.sustain_level =
            (value[16:0] > gre_pkg::SUSTAIN_MAX) ? gre_pkg::SUSTAIN_MAX : value[16:0];
         default: ;
      endcase
   endtask

   task automatic check_registers();
      logic [2:0]                 idx;
      logic [gre_pkg::DATA_W-1:0] got, want, mask;
      for (int r = 0; r <= int'(gre_pkg::REG_SUSTAIN_LEVEL); r++) begin
         idx = r[2:0];
         @(posedge clock);
         csr_psel <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite <= 1'b0;
         csr_paddr <= {idx, 2'b00};
         @(posedge clock);
         csr_penable <= 1'b1;
         @(negedge clock);
         got = csr_prdata;
         @(posedge clock);
         csr_psel <= 1'b0;
         csr_penable <= 1'b0;
         case (idx)
            gre_pkg::REG_TRIGGER_RISE: begin
               want = level_cfg.trigger_rise_level; mask = 32'h7F_FFFF;
            end
            gre_pkg::REG_TRIGGER_FALL: begin
               want = level_cfg.trigger_fall_level; mask = 32'h7F_FFFF;
            end
            gre_pkg::REG_ATTACK_WEIGHT: begin
               want = level_cfg.attack_weight; mask = 32'hFFFF;
            end
            gre_pkg::REG_RELEASE_WGT: begin
               want = level_cfg.release_weight; mask = 32'hFFFF;
            end
            gre_pkg::REG_HOLD_LENGTH: begin
               want = level_cfg.hold_length; mask = 32'hF_FFFF;
            end
            gre_pkg::REG_DECAY_FACTOR: begin
               want = level_cfg.decay_factor; mask = 32'hFF_FFFF;
            end
            gre_pkg::REG_RELEASE_FACT: begin
               want = level_cfg.release_factor; mask = 32'hFF_FFFF;
            end
            default: begin
               want = level_cfg.sustain_level; mask = 32'h1_FFFF;
            end
         endcase
         if ((got & mask) !== want) report_mismatch($sformatf("register %0d readback", r),
                                                    got, want);
      end
   endtask

   task automatic apply_setting(gre_pkg::cfg_type c);
      settle();
      write_reg(gre_pkg::REG_TRIGGER_RISE, 32'(c.trigger_rise_level));
      write_reg(gre_pkg::REG_TRIGGER_FALL, 32'(c.trigger_fall_level));
      write_reg(gre_pkg::REG_ATTACK_WEIGHT, 32'(c.attack_weight));
      write_reg(gre_pkg::REG_RELEASE_WGT, 32'(c.release_weight));
      write_reg(gre_pkg::REG_HOLD_LENGTH, 32'(c.hold_length));
      write_reg(gre_pkg::REG_DECAY_FACTOR, 32'(c.decay_factor));
      write_reg(gre_pkg::REG_RELEASE_FACT, 32'(c.release_factor));
      write_reg(gre_pkg::REG_SUSTAIN_LEVEL, 32'(c.sustain_level));
      check_registers();
   endtask

   initial begin
      gre_pkg::cfg_type c;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      check_registers();

      // field extremes at reset settings; full-scale hits open the gate
      push_beat(24'h7F_FFFF, 24'h00_0000, 1'b0);
      push_beat(24'h80_0000, 24'h00_0000, 1'b1);
      push_beat(24'h00_0000, 24'h80_0000, 1'b0);
      push_beat(24'h00_0000, 24'h7F_FFFF, 1'b1);
      push_beat(24'hFF_FFFF, 24'h00_0001, 1'b0);
      push_beat(24'h00_0000, 24'h00_0000, 1'b0);
      repeat (4) push_beat(24'h7F_FFFF, 24'h80_0000, 1'b0);
      repeat (4) push_beat(24'h00_0000, 24'h00_0000, 1'b1);

      // fast follower, short hold, sustain high enough that a fall arms release
      c = '{trigger_rise_level: 23'd2000000, trigger_fall_level: 23'd1000000,
            attack_weight: 16'd40000, release_weight: 16'd30000, hold_length: 20'd4,
            decay_factor: 24'd14000000, release_factor: 24'd14000000,
            sustain_level: 17'd40000};
      apply_setting(c);
      repeat (4) push_beat(24'h60_0000, 24'hA0_0000, 1'b0);
      repeat (8) push_beat(24'h00_0010, 24'hFF_FFF0, 1'b0);
      run_random(200);

      c = '0;
      apply_setting(c);
      run_random(50);

      c = '{trigger_rise_level: 23'h7F_FFFF, trigger_fall_level: 23'h7F_FFFF,
            attack_weight: 16'hFFFF, release_weight: 16'hFFFF, hold_length: 20'hF_FFFF,
            decay_factor: 24'hFF_FFFF, release_factor: 24'hFF_FFFF,
            sustain_level: 17'h1_FFFF};
      apply_setting(c);
      run_random(50);

      for (int k = 0; k < 4; k++) begin
         c.trigger_rise_level = $urandom_range(4000000, 300000);
         c.trigger_fall_level = $urandom_range(c.trigger_rise_level, 0);
         c.attack_weight = $urandom_range(65535, 6000);
         c.release_weight = $urandom_range(65535, 2000);
         c.hold_length = $urandom_range(24, 0);
         c.decay_factor = $urandom_range(16777215, 12000000);
         c.release_factor = $urandom();
         c.sustain_level = (k == 2) ? 17'd65537 : 17'($urandom_range(70000, 0));
         apply_setting(c);
         if (k == 1) begin
            run_random(75);
            settle();
            run_random(75);
         end else begin
            run_random(150);
         end
      end

      // near-ideal follower, endless decay, release collapses at once
      c = '{trigger_rise_level: 23'd1000, trigger_fall_level: 23'd0,
            attack_weight: 16'hFFFF, release_weight: 16'hFFFF, hold_length: 20'd1,
            decay_factor: 24'hFF_FFFF, release_factor: 24'd0,
            sustain_level: gre_pkg::SUSTAIN_MAX};
      apply_setting(c);
      run_random(100);

      settle();
      if (err_count == 0 && expected_env.size() == 0) begin
         $display("gated_reverb_envelope_generator test passed");
      end else begin
         $display("gated_reverb_envelope_generator test failed");
      end
      $finish;
   end

endmodule

@@ gated_reverb_envelope_generator.f @@
+incdir+sv
sv/gre_pkg.sv
sv/gre_csr.sv
sv/gre_ctrl.sv
sv/gre_dp.sv
sv/gated_reverb_envelope_generator.sv
verif/tb_gated_reverb_envelope_generator.sv
